// ----- design/mnbs_pkg.sv -----
package mnbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  // Field widths of one beat.
  localparam int WHOLE_W = 16;
  localparam int NUMER_W = 16;
  localparam int DENOM_W = 15;
  localparam int SLOT_W = 8;
  localparam int CFG_W = 9;

  // Shared multiplier: 32-bit signed times 16-bit signed plus 16-bit signed addend.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_C_W = 16;
  localparam int PROD_W = 48;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // One stored mixed number.
  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [NUMER_W-1:0] numer;
    logic [DENOM_W-1:0] denom;
  } entry_t;

  // Write request into the table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // Operands for the shared multiply-add unit, as raw two's-complement bits.
  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [MUL_C_W-1:0] c;
  } mul_req_t;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_TB,
    ST_CHECK,
    ST_TA,
    ST_LHS,
    ST_RHS,
    ST_CMP
  } state_t;

endpackage

// ----- design/mnbs_table.sv -----
module mnbs_table
  import mnbs_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/mnbs_mul.sv -----
module mnbs_mul
  import mnbs_pkg::*;
(
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] p
);

  logic signed [PROD_W-1:0] prod;

  // Signed multiply-add; the true result always fits in 48 bits.
  assign prod = $signed(req.a) * $signed(req.b) + $signed(req.c);

  always_ff @(posedge clk) begin
    p <= prod;
  end

endmodule

// ----- design/mnbs_seq.sv -----
module mnbs_seq
  import mnbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [WHOLE_W-1:0] value_whole,
  input  logic [NUMER_W-1:0] value_numerator,
  input  logic [DENOM_W-1:0] value_denominator,
  input  logic [CNT_W-1:0]   count,
  input  entry_t             rd_data,
  input  logic [PROD_W-1:0]  mul_p,
  output logic               busy,
  output tbl_wr_t            tbl_wr,
  output logic [IDX_W-1:0]   rd_addr,
  output mul_req_t           mul_req,
  output logic               done,
  output logic               found,
  output logic [IDX_W-1:0]   hit_index
);

  state_t state;
  state_t state_next;

  logic [WHOLE_W-1:0] key_whole;
  logic [NUMER_W-1:0] key_numer;
  logic [DENOM_W-1:0] key_denom;
  logic [MUL_A_W-1:0] tb;
  logic [PROD_W-1:0]  lhs;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   lim;
  logic [IDX_W-1:0]   mid;
  logic [IDX_W-1:0]   mid_next;
  logic [CNT_W:0]     mid_sum;
  logic               in_range;
  logic               accept;
  logic               is_eq;
  logic               is_lt;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  // Midpoint of the open range [lo, lim).
  assign in_range = (lo < lim);
  assign mid_sum = {1'b0, lo} + {1'b0, lim} - (CNT_W + 1)'(1);
  assign mid_next = (state == ST_CHECK) ? mid_sum[IDX_W:1] : mid;

  // Exact compare of entry against key by cross products.
  assign is_eq = (lhs == mul_p);
  assign is_lt = ($signed(lhs) < $signed(mul_p));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_SEARCH) begin
          state_next = ST_KEY;
        end
      end
      ST_KEY:   state_next = ST_TB;
      ST_TB:    state_next = ST_CHECK;
      ST_CHECK: state_next = in_range ? ST_TA : ST_IDLE;
      ST_TA:    state_next = ST_LHS;
      ST_LHS:   state_next = ST_RHS;
      ST_RHS:   state_next = ST_CMP;
      ST_CMP:   state_next = is_eq ? ST_IDLE : ST_CHECK;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs to the table and the shared multiplier.
  always_comb begin
    tbl_wr.en = accept && (operation == OP_WRITE) &&
                (CNT_W'(slot) < CNT_W'(TABLE_DEPTH));
    tbl_wr.addr = IDX_W'(slot);
    tbl_wr.data.whole = value_whole;
    tbl_wr.data.numer = value_numerator;
    tbl_wr.data.denom = value_denominator;
    rd_addr = mid_next;
    mul_req = '0;
    case (state)
      ST_KEY: begin
        // tb = whole * denom + numer for the key.
        mul_req.a = {{(MUL_A_W - WHOLE_W){key_whole[WHOLE_W-1]}}, key_whole};
        mul_req.b = {1'b0, key_denom};
        mul_req.c = key_numer;
      end
      ST_TA: begin
        // ta = whole * denom + numer for the entry.
        mul_req.a = {{(MUL_A_W - WHOLE_W){rd_data.whole[WHOLE_W-1]}}, rd_data.whole};
        mul_req.b = {1'b0, rd_data.denom};
        mul_req.c = rd_data.numer;
      end
      ST_LHS: begin
        // ta * key denominator.
        mul_req.a = mul_p[MUL_A_W-1:0];
        mul_req.b = {1'b0, key_denom};
      end
      ST_RHS: begin
        // tb * entry denominator.
        mul_req.a = tb;
        mul_req.b = {1'b0, rd_data.denom};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result strobe and result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      found <= 1'b0;
      hit_index <= '0;
    end else begin
      done <= 1'b0;
      if (state == ST_CHECK && !in_range) begin
        done <= 1'b1;
        found <= 1'b0;
        hit_index <= '0;
      end else if (state == ST_CMP && is_eq) begin
        done <= 1'b1;
        found <= 1'b1;
        hit_index <= mid;
      end
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_whole <= value_whole;
      key_numer <= value_numerator;
      key_denom <= value_denominator;
      lo <= '0;
      lim <= count;
    end
    mid <= mid_next;
    if (state == ST_TB) begin
      tb <= mul_p[MUL_A_W-1:0];
    end
    if (state == ST_RHS) begin
      lhs <= mul_p;
    end
    if (state == ST_CMP && !is_eq) begin
      if (is_lt) begin
        lo <= CNT_W'(mid) + CNT_W'(1);
      end else begin
        lim <= CNT_W'(mid);
      end
    end
  end

endmodule

// ----- design/mixed_number_binary_search_core.sv -----
// Write beat: stored at the accepting edge, no result, busy stays low, so writes go back to back.
// Search beat: busy from the accepting edge until the result, through k halving steps
// (k <= 9 for a full 256-entry table); done pulses in the cycle in which busy falls back low.
// Each halving step is a table read and three passes through the one shared multiplier.
// The receiver cannot stall: found and hit_index are valid only in the cycle done is high.
// Synchronous active-high rst clears the sequencer, results and entries_in_use, not the table.
module mixed_number_binary_search_core
  import mnbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [WHOLE_W-1:0] value_whole,
  input  logic [NUMER_W-1:0] value_numerator,
  input  logic [DENOM_W-1:0] value_denominator,
  input  logic               cfg_write,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               done,
  output logic               found,
  output logic [SLOT_W-1:0]  hit_index
);

  logic [CFG_W-1:0]  entries_in_use;
  logic [CNT_W-1:0]  count;
  tbl_wr_t           tbl_wr;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  mul_req_t          mul_req;
  logic [PROD_W-1:0] mul_p;
  logic [IDX_W-1:0]  hit_idx;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_write) begin
      entries_in_use <= cfg_data;
    end
  end

  // Search range is clamped to the table depth.
  assign count = (entries_in_use > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entries_in_use);

  assign hit_index = SLOT_W'(hit_idx);

  mnbs_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .operation         (operation),
    .slot              (slot),
    .value_whole       (value_whole),
    .value_numerator   (value_numerator),
    .value_denominator (value_denominator),
    .count             (count),
    .rd_data           (rd_data),
    .mul_p             (mul_p),
    .busy              (busy),
    .tbl_wr            (tbl_wr),
    .rd_addr           (rd_addr),
    .mul_req           (mul_req),
    .done              (done),
    .found             (found),
    .hit_index         (hit_idx)
  );

  mnbs_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mnbs_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p   (mul_p)
  );

endmodule
